// ===== hw/rtl/vsc_pkg.sv =====
package vsc_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_KEY   = 2'd1,
    OP_TEXT  = 2'd2
  } opcode_e;

  // What the back end does with a text beat
  typedef enum logic {
    KIND_PASS   = 1'b0,
    KIND_LETTER = 1'b1
  } item_kind_e;

  localparam int unsigned AlphaLen = 26;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;

  // Classified text beat, before the key letter is known
  typedef struct packed {
    item_kind_e  kind;
    logic        decrypt;
    logic        bad;
    logic [7:0]  chr;
    logic [4:0]  letter;
  } vsc_text_t;

  // Queue entry: text beat plus its key letter
  typedef struct packed {
    vsc_text_t   text;
    logic [4:0]  key;
  } vsc_item_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CharUpperA) && (c <= CharUpperZ);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CharLowerA) && (c <= CharLowerZ);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return is_upper(c) || is_lower(c);
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  // Letter index 0..25; only meaningful for letters
  function automatic logic [4:0] letter_index(input logic [7:0] c);
    logic [7:0] diff;
    diff = is_upper(c) ? (c - CharUpperA) : (c - CharLowerA);
    return diff[4:0];
  endfunction

endpackage

// ===== hw/rtl/vsc_ram.sv =====
module vsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/vsc_front.sv =====
module vsc_front #(
  parameter int unsigned KeyMax = 32,
  localparam int unsigned AddrW  = (KeyMax > 1) ? $clog2(KeyMax) : 1,
  localparam int unsigned CountW = $clog2(KeyMax + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                decrypt_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          char_in_i,
  // queue push side
  output logic                push_o,
  output vsc_pkg::vsc_item_t  push_item_o,
  input  logic                queue_full_i
);

  logic                 accept;
  logic                 is_letter;
  logic                 is_white;
  logic [4:0]           letter;
  logic [CountW-1:0]    count_q, count_d;
  logic [AddrW-1:0]     pos_q, pos_d;
  logic [CountW-1:0]    pos_inc;
  logic                 key_we;
  logic                 key_re;
  logic [4:0]           key_rdata;
  logic                 stage_valid_q, stage_valid_d;
  logic                 emit;
  vsc_pkg::vsc_text_t   stage_q, stage_d;

  // Stage moves on when the queue has room
  assign push_o     = stage_valid_q & ~queue_full_i;
  assign in_stall_o = stage_valid_q & queue_full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign is_letter = vsc_pkg::is_letter(char_in_i);
  assign is_white  = vsc_pkg::is_white(char_in_i);
  assign letter    = vsc_pkg::letter_index(char_in_i);

  // Next key position, wraps at the key length
  assign pos_inc = CountW'(pos_q) + CountW'(1);

  // Classify the beat and update key bookkeeping
  always_comb begin
    count_d      = count_q;
    pos_d        = pos_q;
    key_we       = 1'b0;
    key_re       = 1'b0;
    emit         = 1'b0;
    stage_d      = stage_q;
    if (accept) begin
      stage_d.kind    = vsc_pkg::KIND_PASS;
      stage_d.decrypt = decrypt_i;
      stage_d.bad     = 1'b1;
      stage_d.chr     = char_in_i;
      stage_d.letter  = letter;
      unique case (vsc_pkg::opcode_e'(opcode_i))
        vsc_pkg::OP_CLEAR: begin
          count_d = '0;
          pos_d   = '0;
        end
        vsc_pkg::OP_KEY: begin
          if (is_letter && (count_q < CountW'(KeyMax))) begin
            key_we  = 1'b1;
            count_d = count_q + CountW'(1);
          end
        end
        vsc_pkg::OP_TEXT: begin
          if (count_q == '0) begin
            emit = 1'b1;
          end else if (is_white) begin
            emit        = decrypt_i;
            stage_d.bad = 1'b0;
          end else if (!is_letter) begin
            emit = 1'b1;
          end else begin
            emit         = 1'b1;
            key_re       = 1'b1;
            stage_d.kind = vsc_pkg::KIND_LETTER;
            stage_d.bad  = 1'b0;
            pos_d        = (pos_inc >= count_q) ? '0 : pos_inc[AddrW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
    stage_valid_d = accept ? emit : (stage_valid_q & ~push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      pos_q         <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      count_q       <= count_d;
      pos_q         <= pos_d;
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  // Key letter store
  vsc_ram #(
    .Width (5),
    .Depth (KeyMax)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (letter),
    .re_i    (key_re),
    .raddr_i (pos_q),
    .rdata_o (key_rdata)
  );

  assign push_item_o.text = stage_q;
  assign push_item_o.key  = key_rdata;

endmodule

// ===== hw/rtl/vsc_queue.sv =====
module vsc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  vsc_pkg::vsc_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output vsc_pkg::vsc_item_t item_o
);

  vsc_pkg::vsc_item_t entry_q [2];
  logic               wptr_q, rptr_q;
  logic [1:0]         count_q;

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign item_o  = entry_q[rptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_item_i;
    end
  end

endmodule

// ===== hw/rtl/vsc_back.sv =====
module vsc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  // queue pop side
  input  logic               item_valid_i,
  input  vsc_pkg::vsc_item_t item_i,
  output logic               pop_o,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         char_out_o,
  output logic               bad_char_o
);

  logic       out_valid_q;
  logic [7:0] char_q, char_d;
  logic       bad_q;
  logic [5:0] sum;
  logic [5:0] diff;
  logic [5:0] shifted;
  logic [4:0] shifted_mod;

  assign pop_o = item_valid_i & (~out_valid_q | ~out_stall_i);

  // Shift the letter by the key, mod 26
  assign sum  = {1'b0, item_i.text.letter} + {1'b0, item_i.key};
  assign diff = {1'b0, item_i.text.letter} + 6'(vsc_pkg::AlphaLen) - {1'b0, item_i.key};
  assign shifted     = item_i.text.decrypt ? diff : sum;
  assign shifted_mod = (shifted >= 6'(vsc_pkg::AlphaLen))
                     ? 5'(shifted - 6'(vsc_pkg::AlphaLen)) : shifted[4:0];

  always_comb begin
    unique case (item_i.text.kind)
      vsc_pkg::KIND_LETTER: begin
        char_d = (item_i.text.decrypt ? vsc_pkg::CharLowerA : vsc_pkg::CharUpperA)
               + {3'b000, shifted_mod};
      end
      vsc_pkg::KIND_PASS: begin
        char_d = item_i.text.chr;
      end
      default: begin
        char_d = item_i.text.chr;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      char_q <= char_d;
      bad_q  <= item_i.text.bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign bad_char_o  = bad_q;

endmodule

// ===== hw/rtl/vigenere_stream_cipher_core.sv =====
// Vigenere stream cipher core.
// Input channel (in_valid_i / in_stall_o) carries one beat per item: opcode_i
// selects clear key, append key letter (char_in_i) or process text (char_in_i).
// Output channel (out_valid_o / out_stall_i) carries char_out_o and bad_char_o
// for text beats only; key, clear and unused-opcode beats, and whitespace
// while encrypting with a key loaded, give no output beat. Cipher text is upper
// case, plain text lower case. Register 0 at byte address 0 of the APB port:
// bit 0 selects decrypt mode. Write it only while the core is empty.
// Throughput: one beat per clock while out_stall_i is low. A beat passes
// through the front stage with the key RAM read, the queue and the output
// register before its result appears on the output channel.
// The key RAM's registered read port sets the front stage.
// A two-entry queue sits between front and back end. When out_stall_i is held
// the output register, the queue and the front stage fill in turn, and then
// in_stall_o rises; nothing is lost or repeated.
// Reset empties the key and the pipeline and selects encrypt mode. Key RAM
// contents are not cleared; only entries below the key length are read.
module vigenere_stream_cipher_core #(
  parameter int unsigned KeyMax = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  char_in_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  char_out_o,
  output logic        bad_char_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               decrypt_q;
  logic               reg_hit;
  logic               push;
  logic               queue_full;
  logic               pop;
  logic               queue_valid;
  vsc_pkg::vsc_item_t push_item;
  vsc_pkg::vsc_item_t queue_item;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'b0);
  assign prdata  = reg_hit ? {31'd0, decrypt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      decrypt_q <= pwdata[0];
    end
  end

  vsc_front #(
    .KeyMax (KeyMax)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .decrypt_i    (decrypt_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .char_in_i    (char_in_i),
    .push_o       (push),
    .push_item_o  (push_item),
    .queue_full_i (queue_full)
  );

  vsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (queue_valid),
    .item_o      (queue_item)
  );

  vsc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_out_o   (char_out_o),
    .bad_char_o   (bad_char_o)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int KeyMax = 32;
  localparam int CycleLimit = 200000;
  localparam int PhaseBeats = 50;
  localparam int NumPhases = 8;
  localparam int NumDirected = 24;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [2:0] AddrDecryptMode = 3'd0;

  // one result beat of the cipher
  typedef struct packed {
    logic [7:0] chr;
    logic       bad;
  } cipher_out_t;

  // directed row: either a mode write (chr bit 0) or an input beat
  typedef struct packed {
    logic       cfg;
    logic [1:0] op;
    logic [7:0] chr;
    logic       typed;
    logic [7:0] exp_chr;
    logic       exp_bad;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  logic [7:0]  char_in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  char_out_o;
  logic        bad_char_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [4:0]  key_mem [KeyMax];
  int          key_len;
  int          key_pos;
  logic        mode_decrypt;

  cipher_out_t pending_chars [$];
  dir_row_t    dir_rows [NumDirected];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int cycles;
  int errs;
  int shown;
  int n_beats;
  int n_checked;
  int n_key_full;
  int n_held_off;

  vigenere_stream_cipher_core #(
    .KeyMax(KeyMax)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .char_in_i  (char_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .char_out_o (char_out_o),
    .bad_char_o (bad_char_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void note_error(input string msg);
    errs++;
    if (shown < 10) begin
      shown++;
      $display("tb: mismatch at cycle %0d: %s", cycles, msg);
    end
  endfunction

  // Cipher step on the local state; has is set when the beat yields a result
  task automatic predict_cipher(input logic [1:0] op, input logic [7:0] c,
                                output bit has, output cipher_out_t r);
    bit         up;
    bit         letter;
    bit         white;
    logic [4:0] v;
    int         k;
    has = 1'b0;
    r = '0;
    up = c inside {[vsc_pkg::CharUpperA:vsc_pkg::CharUpperZ]};
    letter = up || (c inside {[vsc_pkg::CharLowerA:vsc_pkg::CharLowerZ]});
    white = (c == vsc_pkg::CharSpace) || (c >= vsc_pkg::CharTab && c <= vsc_pkg::CharCr);
    v = up ? 5'(c - vsc_pkg::CharUpperA) : 5'(c - vsc_pkg::CharLowerA);
    case (op)
      vsc_pkg::OP_CLEAR: begin
        key_len = 0;
        key_pos = 0;
      end
      vsc_pkg::OP_KEY: begin
        if (letter && key_len < KeyMax) begin
          key_mem[key_len] = v;
          key_len++;
        end else if (letter) begin
          n_key_full++;
        end
      end
      vsc_pkg::OP_TEXT: begin
        if (key_len == 0) begin
          has = 1'b1;
          r = '{chr: c, bad: 1'b1};
        end else if (white) begin
          // dropped while encrypting, passed clean while decrypting
          if (mode_decrypt) begin
            has = 1'b1;
            r = '{chr: c, bad: 1'b0};
          end
        end else if (!letter) begin
          has = 1'b1;
          r = '{chr: c, bad: 1'b1};
        end else begin
          if (key_pos >= key_len) key_pos = 0;
          k = key_mem[key_pos];
          has = 1'b1;
          if (mode_decrypt) begin
            r.chr = vsc_pkg::CharLowerA
                  + 8'((int'(v) + vsc_pkg::AlphaLen - k) % vsc_pkg::AlphaLen);
          end else begin
            r.chr = vsc_pkg::CharUpperA + 8'((int'(v) + k) % vsc_pkg::AlphaLen);
          end
          r.bad = 1'b0;
          key_pos++;
          if (key_pos >= key_len) key_pos = 0;
        end
      end
      default: ;
    endcase
  endtask

  // Offer one beat, wait for acceptance, then queue what it should produce
  task automatic send_beat(input logic [1:0] op, input logic [7:0] c,
                           input bit typed, input cipher_out_t typed_out);
    bit          has;
    cipher_out_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    char_in_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    n_beats++;
    predict_cipher(op, c, has, r);
    if (typed) pending_chars.push_back(typed_out);
    else if (has) pending_chars.push_back(r);
  endtask

  task automatic send_plain(input logic [1:0] op, input logic [7:0] c);
    send_beat(op, c, 1'b0, '0);
  endtask

  // Mode change only with the core empty
  task automatic write_mode(input logic m);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrDecryptMode;
    pwdata  <= {31'b0, m};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mode_decrypt = m;
    // read back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== m) begin
      note_error($sformatf("mode read back %b, wrote %b", prdata[0], m));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) ? vsc_pkg::CharLowerA : vsc_pkg::CharUpperA)
           + 8'($urandom_range(25));
  endfunction

  // One message: clear, key, text, with some noise mixed in
  task automatic send_message();
    int         pick;
    int         klen;
    int         tlen;
    logic [7:0] c;
    if ($urandom_range(9) != 0) send_plain(vsc_pkg::OP_CLEAR, 8'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 8) klen = 0;
    else if (pick < 70) klen = $urandom_range(6, 1);
    else if (pick < 90) klen = $urandom_range(31, 7);
    else klen = $urandom_range(40, 32);
    for (int i = 0; i < klen; i++) begin
      if ($urandom_range(9) == 0) send_plain(vsc_pkg::OP_KEY, 8'($urandom_range(255)));
      send_plain(vsc_pkg::OP_KEY, rand_letter());
    end
    tlen = $urandom_range(16, 1);
    for (int i = 0; i < tlen; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) c = rand_letter();
      else if (pick < 80) c = $urandom_range(5) == 0 ? vsc_pkg::CharSpace
                                                     : vsc_pkg::CharTab + 8'($urandom_range(4));
      else if (pick < 90) c = 8'($urandom_range(64, 33));
      else c = 8'($urandom_range(255));
      if ($urandom_range(39) == 0) send_plain(OpUnused, 8'($urandom_range(255)));
      send_plain(vsc_pkg::OP_TEXT, c);
    end
  endtask

  // Receiver: random stalls plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin
    cipher_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        note_error($sformatf("unexpected beat char=%h bad=%b", char_out_o, bad_char_o));
      end else begin
        want = pending_chars.pop_front();
        n_checked++;
        if (char_out_o !== want.chr || bad_char_o !== want.bad) begin
          note_error($sformatf("char exp %h got %h, bad exp %b got %b",
                               want.chr, char_out_o, want.bad, bad_char_o));
        end
      end
    end
    if (rst_ni && in_valid_i && in_stall_o) n_held_off++;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int          start;
    int          waited;
    cipher_out_t typed_out;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = vsc_pkg::OP_CLEAR;
    char_in_i = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = AddrDecryptMode;
    pwdata = 32'h0;
    mode_decrypt = 1'b0;
    key_len = 0;
    key_pos = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    cycles = 0;
    errs = 0;
    shown = 0;
    n_beats = 0;
    n_checked = 0;
    n_key_full = 0;
    n_held_off = 0;

    dir_rows = '{
      // empty key: every text beat passes flagged, whitespace too
      '{1'b0, vsc_pkg::OP_TEXT,  8'h41, 1'b1, 8'h41, 1'b1},
      '{1'b0, vsc_pkg::OP_TEXT,  8'h00, 1'b1, 8'h00, 1'b1},
      '{1'b0, vsc_pkg::OP_TEXT,  8'hFF, 1'b1, 8'hFF, 1'b1},
      '{1'b0, vsc_pkg::OP_TEXT,  8'h20, 1'b1, 8'h20, 1'b1},
      // key load with non-letters and the unused opcode ignored
      '{1'b0, vsc_pkg::OP_KEY,   8'h40, 1'b0, 8'h00, 1'b0},
      '{1'b0, vsc_pkg::OP_KEY,   8'h42, 1'b0, 8'h00, 1'b0},
      '{1'b0, vsc_pkg::OP_KEY,   8'h7A, 1'b0, 8'h00, 1'b0},
      '{1'b0, vsc_pkg::OP_KEY,   8'h5B, 1'b0, 8'h00, 1'b0},
      '{1'b0, OpUnused,          8'h41, 1'b0, 8'h00, 1'b0},
      // encrypt: letters at both ends, wrap mod 26, whitespace dropped
      '{1'b0, vsc_pkg::OP_TEXT,  8'h41, 1'b0, 8'h00, 1'b0},
      '{1'b0, vsc_pkg::OP_TEXT,  8'h7A, 1'b0, 8'h00, 1'b0},
      '{1'b0, vsc_pkg::OP_TEXT,  8'h5A, 1'b0, 8'h00, 1'b0},
      '{1'b0, vsc_pkg::OP_TEXT,  8'h20, 1'b0, 8'h00, 1'b0},
      '{1'b0, vsc_pkg::OP_TEXT,  8'h0D, 1'b0, 8'h00, 1'b0},
      '{1'b0, vsc_pkg::OP_TEXT,  8'h30, 1'b1, 8'h30, 1'b1},
      '{1'b0, vsc_pkg::OP_TEXT,  8'h60, 1'b1, 8'h60, 1'b1},
      // decrypt: whitespace passed clean, neighbors of whitespace flagged
      '{1'b1, vsc_pkg::OP_CLEAR, 8'h01, 1'b0, 8'h00, 1'b0},
      '{1'b0, vsc_pkg::OP_TEXT,  8'h61, 1'b0, 8'h00, 1'b0},
      '{1'b0, vsc_pkg::OP_TEXT,  8'h5A, 1'b0, 8'h00, 1'b0},
      '{1'b0, vsc_pkg::OP_TEXT,  8'h09, 1'b1, 8'h09, 1'b0},
      '{1'b0, vsc_pkg::OP_TEXT,  8'h0E, 1'b1, 8'h0E, 1'b1},
      // clear, then empty key again
      '{1'b0, vsc_pkg::OP_CLEAR, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{1'b0, vsc_pkg::OP_TEXT,  8'h6D, 1'b1, 8'h6D, 1'b1},
      '{1'b1, vsc_pkg::OP_CLEAR, 8'h00, 1'b0, 8'h00, 1'b0}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg) begin
        write_mode(dir_rows[i].chr[0]);
      end else begin
        typed_out = '{chr: dir_rows[i].exp_chr, bad: dir_rows[i].exp_bad};
        send_beat(dir_rows[i].op, dir_rows[i].chr, dir_rows[i].typed, typed_out);
      end
    end

    // random phases over idle profiles and both modes
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_mode(1'((ph + ph / 4) % 2));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      // long receiver hold-off so the pipeline fills and the input stalls
      if (ph == 4) hold_req = 150;
      start = n_beats;
      while (n_beats - start < PhaseBeats) send_message();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_chars.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      note_error($sformatf("%0d results never arrived", pending_chars.size()));
    end

    $display("tb: %0d beats in, %0d results checked, both modes, four idle profiles",
             n_beats, n_checked);
    $display("tb: %0d key letters past a full key, input held off %0d cycles, %0d errors",
             n_key_full, n_held_off, errs);
    if (errs == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
